/* rtl/core/fwr_pkg.sv */
// ----------------------------------------------------------------------------
// fwr_pkg
// Shared types and sizes for the queue with search and remove by id.
// ----------------------------------------------------------------------------
package fwr_pkg;

	localparam int DEPTH    = 16;
	localparam int HANDLE_W = 16;
	localparam int ID_W     = 16;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_REMOVE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [CNT_W-1:0]    count;
		logic [HANDLE_W-1:0] front;
		logic [HANDLE_W-1:0] back;
	} result_t;

endpackage

/* rtl/core/fwr_mem.sv */
// ----------------------------------------------------------------------------
// fwr_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fwr_mem (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [fwr_pkg::IDX_W-1:0] wr_addr,
	input  fwr_pkg::entry_t           wr_data,
	input  logic                      rd_en,
	input  logic [fwr_pkg::IDX_W-1:0] rd_addr,
	output fwr_pkg::entry_t           rd_data
);
	import fwr_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/fwr_seq.sv */
// ----------------------------------------------------------------------------
// fwr_seq
// Operation sequencer: scans, compacts and refreshes front and back handles.
// ----------------------------------------------------------------------------
module fwr_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [1:0]                   action,
	input  logic [fwr_pkg::HANDLE_W-1:0] entry_handle,
	input  logic [fwr_pkg::ID_W-1:0]     entry_id,
	output logic                         busy,
	output logic                         res_valid,
	input  logic                         res_take,
	output fwr_pkg::result_t             res
);
	import fwr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RD_FRONT,
		S_RD_BACK,
		S_GOT_BACK,
		S_OUT
	} state_t;

	state_t              state_q;
	action_t             act_q;
	logic [ID_W-1:0]     key_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    src_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [HANDLE_W-1:0] front_q;
	logic [HANDLE_W-1:0] back_q;
	logic                rd_v_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	entry_t              rd_data;
	logic                hit;
	logic                full;
	logic [CNT_W-1:0]    count_dec;

	fwr_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign full      = (count_q >= CNT_W'(DEPTH));
	assign count_dec = count_q - CNT_W'(1);
	assign hit       = (state_q == S_SCAN) && rd_v_s1
		&& ((act_q == ACT_POP) || (rd_data.id == key_q));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = src_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = '{handle: entry_handle, id: entry_id};
		unique case (state_q)
			S_IDLE: begin
				wr_en = in_valid && (action_t'(action) == ACT_PUSH) && !full;
			end
			S_SCAN: begin
				rd_en = (src_q < count_q) && !hit;
			end
			S_SHIFT: begin
				rd_en   = (src_q < count_q);
				wr_en   = rd_v_s1;
				wr_addr = rd_idx_s1 - IDX_W'(1);
				wr_data = rd_data;
			end
			S_RD_FRONT: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_RD_BACK: begin
				rd_en   = 1'b1;
				rd_addr = count_dec[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_v_s1      <= 1'b0;
			act_q        <= ACT_PUSH;
			key_q        <= '0;
			src_q        <= '0;
			status_q     <= ST_DONE;
			res_handle_q <= '0;
			front_q      <= '0;
			back_q       <= '0;
			rd_idx_s1    <= '0;
		end else begin
			rd_v_s1   <= rd_en;
			rd_idx_s1 <= rd_addr;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q        <= action_t'(action);
						key_q        <= entry_id;
						src_q        <= '0;
						res_handle_q <= '0;
						if (action_t'(action) == ACT_PUSH) begin
							state_q <= S_RD_FRONT;
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_DONE;
								count_q  <= count_q + CNT_W'(1);
							end
						end else begin
							status_q <= ST_MISS;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						status_q     <= ST_DONE;
						res_handle_q <= rd_data.handle;
						if (act_q == ACT_FIND) begin
							state_q <= S_RD_FRONT;
						end else begin
							src_q   <= CNT_W'(rd_idx_s1) + CNT_W'(1);
							state_q <= S_SHIFT;
						end
					end else if (!rd_v_s1 && !rd_en) begin
						status_q <= ST_MISS;
						if (count_q == '0) begin
							front_q <= '0;
							back_q  <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD_FRONT;
						end
					end else if (rd_en) begin
						src_q <= src_q + CNT_W'(1);
					end
				end
				S_SHIFT: begin
					if (rd_en) begin
						src_q <= src_q + CNT_W'(1);
					end else if (!rd_v_s1) begin
						count_q <= count_dec;
						if (count_dec == '0) begin
							front_q <= '0;
							back_q  <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD_FRONT;
						end
					end
				end
				S_RD_FRONT: begin
					state_q <= S_RD_BACK;
				end
				S_RD_BACK: begin
					front_q <= rd_data.handle;
					state_q <= S_GOT_BACK;
				end
				S_GOT_BACK: begin
					back_q  <= rd_data.handle;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res       = '{status: status_q, handle: res_handle_q, count: count_q,
		front: front_q, back: back_q};

endmodule

/* rtl/core/fifo_with_remove_by_id.sv */
// ----------------------------------------------------------------------------
// fifo_with_remove_by_id
// Bounded queue of handle and id entries with push, pop, find and remove.
//
//   channel  beat                                      direction
//   in       action, entry_handle, entry_id            in_valid / in_stall
//   out      status, result_handle, entry_count,       out_valid / out_stall
//            front_handle, back_handle
//
// One beat at a time through the sequencer and its entry store.
// Push writes unless full, then refreshes front and back; find scans the store;
// pop and remove scan, then compact the entries behind the hit, one a cycle.
// Reset empties the queue; the store itself is not cleared.
// A finished result waits in the output register while the next beat enters;
// a second finished result holds the sequencer, and in_stall, until it drains.
// ----------------------------------------------------------------------------
module fifo_with_remove_by_id (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [fwr_pkg::HANDLE_W-1:0] entry_handle,
	input  logic [fwr_pkg::ID_W-1:0]     entry_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [fwr_pkg::HANDLE_W-1:0] result_handle,
	output logic [fwr_pkg::CNT_W-1:0]    entry_count,
	output logic [fwr_pkg::HANDLE_W-1:0] front_handle,
	output logic [fwr_pkg::HANDLE_W-1:0] back_handle
);
	import fwr_pkg::*;

	logic    busy;
	logic    res_valid;
	logic    res_take;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	fwr_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.action       (action),
		.entry_handle (entry_handle),
		.entry_id     (entry_id),
		.busy         (busy),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res)
	);

	assign res_take = !out_valid_q || !out_stall;
	assign in_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign result_handle = out_q.handle;
	assign entry_count   = out_q.count;
	assign front_handle  = out_q.front;
	assign back_handle   = out_q.back;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(DEPTH)))
		else $error("entry count beyond depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (entry_count == CNT_W'(DEPTH))
			&& (result_handle == '0))
		else $error("push dropped while not full");

	a_miss_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_MISS) |-> (result_handle == '0))
		else $error("miss reports a handle");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_count == '0) |-> (front_handle == '0)
			&& (back_handle == '0))
		else $error("empty queue reports front or back");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while busy");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded handle/id queue with find and remove.
// A short table of directed beats covers the empty, full, zero-handle,
// duplicate-id and miss cases, then random traffic swings the queue between
// full and empty under four idling phases. Every result beat is checked
// field by field against the typed table result or a shadow queue of the block.
// ----------------------------------------------------------------------------
module tb_top;
	import fwr_pkg::*;

	localparam int N_ROWS      = 14;
	localparam int BEATS_PHASE = 384;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		action_t             act;
		logic [HANDLE_W-1:0] handle;
		logic [ID_W-1:0]     id;
		int                  reps;
		bit                  typed;
		result_t             want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          action = ACT_PUSH;
	logic [HANDLE_W-1:0] entry_handle = '0;
	logic [ID_W-1:0]     entry_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] result_handle;
	logic [CNT_W-1:0]    entry_count;
	logic [HANDLE_W-1:0] front_handle;
	logic [HANDLE_W-1:0] back_handle;

	entry_t      shadow_entries[$];
	result_t     pending_results[$];
	stim_row_t   directed_rows[N_ROWS];
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          error_count = 0;
	int          quiet_cycles = 0;

	fifo_with_remove_by_id uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.entry_handle  (entry_handle),
		.entry_id      (entry_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.result_handle (result_handle),
		.entry_count   (entry_count),
		.front_handle  (front_handle),
		.back_handle   (back_handle)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t step_entry_queue(action_t act, logic [HANDLE_W-1:0] h,
			logic [ID_W-1:0] key);
		result_t r;
		entry_t  e;
		int      hit;
		r = '0;
		r.status = ST_DONE;
		hit = -1;
		case (act)
			ACT_PUSH: begin
				if (shadow_entries.size() >= DEPTH) r.status = ST_FULL;
				else begin
					e.handle = h;
					e.id = key;
					shadow_entries.push_back(e);
				end
			end
			ACT_POP: begin
				if (shadow_entries.size() == 0) r.status = ST_MISS;
				else begin
					e = shadow_entries.pop_front();
					r.handle = e.handle;
				end
			end
			ACT_FIND, ACT_REMOVE: begin
				for (int k = 0; k < shadow_entries.size() && hit < 0; k++)
					if (shadow_entries[k].id == key) hit = k;
				if (hit < 0) r.status = ST_MISS;
				else begin
					r.handle = shadow_entries[hit].handle;
					if (act == ACT_REMOVE) shadow_entries.delete(hit);
				end
			end
		endcase
		r.count = CNT_W'(shadow_entries.size());
		if (shadow_entries.size() > 0) begin
			r.front = shadow_entries[0].handle;
			r.back = shadow_entries[shadow_entries.size() - 1].handle;
		end
		return r;
	endfunction

	// present one beat after an optional gap, hold it until taken
	task automatic send_beat(action_t act, logic [HANDLE_W-1:0] h, logic [ID_W-1:0] key,
			bit typed, result_t typed_want);
		int      gap;
		result_t predicted;
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		entry_handle <= h;
		entry_id     <= key;
		do @(posedge clk); while (in_stall);
		predicted = step_entry_queue(act, h, key);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (result_handle !== want.handle) begin
					$error("result_handle: expected %h, got %h", want.handle, result_handle);
					error_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					error_count++;
				end
				if (front_handle !== want.front) begin
					$error("front_handle: expected %h, got %h", want.front, front_handle);
					error_count++;
				end
				if (back_handle !== want.back) begin
					$error("back_handle: expected %h, got %h", want.back, back_handle);
					error_count++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int unsigned         idle_plan[4];
		int unsigned         stall_plan[4];
		logic [ID_W-1:0]     key_pool[6];
		int unsigned         push_w;
		action_t             act;
		logic [HANDLE_W-1:0] h;
		logic [ID_W-1:0]     key;

		idle_plan  = '{0, 86, 0, 32};
		stall_plan = '{0, 0, 86, 32};
		directed_rows = '{
			'{ACT_POP,    16'h0000, 16'h0000, 1,  1'b1, '{ST_MISS, 16'h0, 5'd0, 16'h0, 16'h0}},
			'{ACT_FIND,   16'h0000, 16'hFFFF, 1,  1'b1, '{ST_MISS, 16'h0, 5'd0, 16'h0, 16'h0}},
			'{ACT_REMOVE, 16'hFFFF, 16'h0000, 1,  1'b1, '{ST_MISS, 16'h0, 5'd0, 16'h0, 16'h0}},
			'{ACT_PUSH,   16'hFFFF, 16'hFFFF, 1,  1'b1,
				'{ST_DONE, 16'h0, 5'd1, 16'hFFFF, 16'hFFFF}},
			'{ACT_PUSH,   16'h0000, 16'h0000, 1,  1'b1,
				'{ST_DONE, 16'h0, 5'd2, 16'hFFFF, 16'h0000}},
			'{ACT_PUSH,   16'h1000, 16'h00A5, 14, 1'b0, '0},
			'{ACT_PUSH,   16'h5555, 16'hAAAA, 1,  1'b1,
				'{ST_FULL, 16'h0, 5'd16, 16'hFFFF, 16'h100D}},
			'{ACT_FIND,   16'h0000, 16'h0000, 1,  1'b0, '0},
			'{ACT_FIND,   16'h1234, 16'h1234, 1,  1'b0, '0},
			'{ACT_REMOVE, 16'h0000, 16'h00A5, 1,  1'b0, '0},
			'{ACT_REMOVE, 16'h0000, 16'hFFFF, 1,  1'b0, '0},
			'{ACT_POP,    16'hAAAA, 16'h5555, 1,  1'b0, '0},
			'{ACT_PUSH,   16'hAAAA, 16'h5555, 1,  1'b0, '0},
			'{ACT_REMOVE, 16'h0000, 16'h5555, 1,  1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			for (int k = 0; k < directed_rows[i].reps; k++)
				send_beat(directed_rows[i].act, HANDLE_W'(directed_rows[i].handle + k),
					directed_rows[i].id, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_plan[p];
			recv_stall_pct  = stall_plan[p];
			push_w = 70;
			for (int n = 0; n < BEATS_PHASE; n++) begin
				// swing between filling and draining, refresh the keys
				if (n % 40 == 0) begin
					push_w = (push_w == 70) ? 25 : 70;
					foreach (key_pool[j]) key_pool[j] = ID_W'($urandom_range(0, 65535));
				end
				if ($urandom_range(0, 99) < push_w) act = ACT_PUSH;
				else act = action_t'($urandom_range(1, 3));
				if (act == ACT_PUSH && $urandom_range(0, 29) != 0)
					h = HANDLE_W'($urandom_range(1, 65535));
				else if (act == ACT_PUSH) h = '0;
				else h = HANDLE_W'($urandom_range(0, 65535));
				if ($urandom_range(0, 4) != 0) key = key_pool[$urandom_range(0, 5)];
				else key = ID_W'($urandom_range(0, 65535));
				send_beat(act, h, key, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
